@@ design/mco_pkg.sv @@
`timescale 1ns / 1ps
// Package for the midpoint circle outline unit.
// Holds the command codes, the octant order of the emitted points and the
// launch record between the step core and the point emitter. No dependencies.
package mco_pkg;

  // Command codes of an input item.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP  = 1'b1;

  // Eight mirrored points per step, emitted in this order.
  localparam int unsigned POINTS_PER_STEP = 8;
  localparam int unsigned IDX_BITS        = 3;

  localparam logic [IDX_BITS-1:0] OCT_PX_MY = 3'd0;  // (cx+x, cy-y)
  localparam logic [IDX_BITS-1:0] OCT_PX_PY = 3'd1;  // (cx+x, cy+y)
  localparam logic [IDX_BITS-1:0] OCT_MX_MY = 3'd2;  // (cx-x, cy-y)
  localparam logic [IDX_BITS-1:0] OCT_MX_PY = 3'd3;  // (cx-x, cy+y)
  localparam logic [IDX_BITS-1:0] OCT_PY_MX = 3'd4;  // (cx+y, cy-x)
  localparam logic [IDX_BITS-1:0] OCT_PY_PX = 3'd5;  // (cx+y, cy+x)
  localparam logic [IDX_BITS-1:0] OCT_MY_MX = 3'd6;  // (cx-y, cy-x)
  localparam logic [IDX_BITS-1:0] OCT_MY_PX = 3'd7;  // (cx-y, cy+x)

  // Handoff from the step core to the point emitter.
  typedef struct packed {
    logic go;   // a step item was accepted and has eight points to emit
    logic fin;  // the circle is complete after this step
  } launch_t;

endpackage

@@ design/mco_core.sv @@
`timescale 1ns / 1ps
// Step core of the midpoint circle outline unit: command handshake, the
// walk state and its one-step update. Depends on mco_pkg.
module mco_core #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic                          command,
  input  logic [COORD_BITS-1:0]         centre_x,
  input  logic [COORD_BITS-1:0]         centre_y,
  input  logic [RADIUS_BITS-1:0]        circle_radius,
  input  logic                          emit_free,
  output mco_pkg::launch_t              launch,
  output logic signed [RADIUS_BITS:0]   step_x,
  output logic [RADIUS_BITS-1:0]        step_y,
  output logic [COORD_BITS-1:0]         step_cx,
  output logic [COORD_BITS-1:0]         step_cy
);

  localparam int XW = RADIUS_BITS + 1;
  localparam int TW = RADIUS_BITS + 1;
  localparam int EW = RADIUS_BITS + 3;

  logic signed [XW-1:0]   pos_x;
  logic [RADIUS_BITS-1:0] pos_y;
  logic [TW-1:0]          step_tx;
  logic [TW-1:0]          step_ty;
  logic signed [EW-1:0]   error_term;
  logic [COORD_BITS-1:0]  held_centre_x;
  logic [COORD_BITS-1:0]  held_centre_y;
  logic [RADIUS_BITS-1:0] held_radius;
  logic                   active;

  logic                   accept;
  logic                   step_ok;
  logic                   err_le0;
  logic                   dec_x;
  logic [RADIUS_BITS-1:0] y_next;
  logic signed [XW-1:0]   x_next;
  logic [TW-1:0]          tx_next;
  logic [TW-1:0]          ty_next;
  logic signed [EW-1:0]   err_mid;
  logic signed [EW-1:0]   err_next;
  logic                   fin;
  logic signed [XW-1:0]   start_x;
  logic signed [EW-1:0]   start_err;

  assign cmd_ready = emit_free;
  assign accept    = cmd_valid && cmd_ready;
  assign step_ok   = active && !(pos_x < $signed({1'b0, pos_y}));

  // One midpoint update: possibly move up in y, then possibly move in x.
  always_comb begin
    err_le0  = (error_term <= $signed(EW'(0)));
    y_next   = err_le0 ? pos_y + RADIUS_BITS'(1) : pos_y;
    err_mid  = err_le0 ? error_term + $signed({2'b00, step_ty}) : error_term;
    ty_next  = err_le0 ? step_ty + TW'(2) : step_ty;
    dec_x    = (err_mid > $signed(EW'(0)));
    x_next   = dec_x ? pos_x - $signed(XW'(1)) : pos_x;
    tx_next  = dec_x ? step_tx + TW'(2) : step_tx;
    err_next = dec_x ? err_mid + $signed({2'b00, tx_next})
                       - $signed({1'b0, held_radius, 1'b0})
                     : err_mid;
    fin      = (x_next < $signed({1'b0, y_next}));
  end

  assign start_x   = $signed({1'b0, circle_radius}) - $signed(XW'(1));
  assign start_err = $signed(EW'(1)) - $signed({2'b00, circle_radius, 1'b0});

  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x         <= '0;
      pos_y         <= '0;
      step_tx       <= TW'(1);
      step_ty       <= TW'(1);
      error_term    <= '0;
      held_centre_x <= '0;
      held_centre_y <= '0;
      held_radius   <= '0;
      active        <= 1'b0;
    end else if (accept) begin
      if (command == mco_pkg::CMD_START) begin
        held_centre_x <= centre_x;
        held_centre_y <= centre_y;
        held_radius   <= circle_radius;
        pos_x         <= start_x;
        pos_y         <= '0;
        step_tx       <= TW'(1);
        step_ty       <= TW'(1);
        error_term    <= start_err;
        // A zero radius starts with x below y and never becomes active.
        active        <= (circle_radius != '0);
      end else if (step_ok) begin
        pos_x      <= x_next;
        pos_y      <= y_next;
        step_tx    <= tx_next;
        step_ty    <= ty_next;
        error_term <= err_next;
        active     <= !fin;
      end else begin
        active <= 1'b0;
      end
    end
  end

  assign launch.go  = accept && (command == mco_pkg::CMD_STEP) && step_ok;
  assign launch.fin = fin;
  assign step_x     = pos_x;
  assign step_y     = pos_y;
  assign step_cx    = held_centre_x;
  assign step_cy    = held_centre_y;

  // While a circle is in progress the walk has not crossed the diagonal.
  a_active_valid: assert property (@(posedge clk) disable iff (rst)
    active |-> !(pos_x < $signed({1'b0, pos_y})))
    else $error("active with x below y");

  // The step that crosses the diagonal ends the circle.
  a_fin_clears: assert property (@(posedge clk) disable iff (rst)
    (launch.go && launch.fin) |=> !active)
    else $error("circle still active after final step");

  // A launch only happens when the emitter can take it.
  a_go_free: assert property (@(posedge clk) disable iff (rst)
    launch.go |-> emit_free)
    else $error("launch while emitter busy");

endmodule

@@ design/mco_emit.sv @@
`timescale 1ns / 1ps
// Point emitter of the midpoint circle outline unit: holds one step's
// position and walks the eight mirrored points into the result register.
// Depends on mco_pkg.
module mco_emit #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  mco_pkg::launch_t              launch,
  input  logic signed [RADIUS_BITS:0]   step_x,
  input  logic [RADIUS_BITS-1:0]        step_y,
  input  logic [COORD_BITS-1:0]         step_cx,
  input  logic [COORD_BITS-1:0]         step_cy,
  output logic                          emit_free,
  output logic                          pt_valid,
  input  logic                          pt_ready,
  output logic signed [COORD_BITS+1:0]  point_x,
  output logic signed [COORD_BITS+1:0]  point_y,
  output logic                          last,
  output logic                          done_res
);

  localparam int PW = COORD_BITS + 2;
  localparam int AW = COORD_BITS + RADIUS_BITS + 4;
  localparam logic [mco_pkg::IDX_BITS-1:0] IDX_LAST =
    mco_pkg::IDX_BITS'(mco_pkg::POINTS_PER_STEP - 1);

  logic                              busy;
  logic [mco_pkg::IDX_BITS-1:0]      idx;
  logic signed [RADIUS_BITS:0]       ex;
  logic [RADIUS_BITS-1:0]            ey;
  logic [COORD_BITS-1:0]             ecx;
  logic [COORD_BITS-1:0]             ecy;
  logic                              efin;

  logic                              adv;
  logic [AW-1:0]                     cxw;
  logic [AW-1:0]                     cyw;
  logic [AW-1:0]                     xw;
  logic [AW-1:0]                     yw;
  logic [AW-1:0]                     sel_x;
  logic [AW-1:0]                     sel_y;

  // The result register takes a new point when it is empty or being drained.
  assign adv       = busy && (!pt_valid || pt_ready);
  assign emit_free = !busy || ((idx == IDX_LAST) && adv);

  assign cxw = AW'(ecx);
  assign cyw = AW'(ecy);
  assign xw  = AW'(ex);
  assign yw  = AW'(ey);

  always_comb begin
    unique case (idx)
      mco_pkg::OCT_PX_MY: begin sel_x = cxw + xw; sel_y = cyw - yw; end
      mco_pkg::OCT_PX_PY: begin sel_x = cxw + xw; sel_y = cyw + yw; end
      mco_pkg::OCT_MX_MY: begin sel_x = cxw - xw; sel_y = cyw - yw; end
      mco_pkg::OCT_MX_PY: begin sel_x = cxw - xw; sel_y = cyw + yw; end
      mco_pkg::OCT_PY_MX: begin sel_x = cxw + yw; sel_y = cyw - xw; end
      mco_pkg::OCT_PY_PX: begin sel_x = cxw + yw; sel_y = cyw + xw; end
      mco_pkg::OCT_MY_MX: begin sel_x = cxw - yw; sel_y = cyw - xw; end
      mco_pkg::OCT_MY_PX: begin sel_x = cxw - yw; sel_y = cyw + xw; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (launch.go) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (adv) begin
      busy <= (idx != IDX_LAST);
      idx  <= idx + mco_pkg::IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (launch.go) begin
      ex   <= step_x;
      ey   <= step_y;
      ecx  <= step_cx;
      ecy  <= step_cy;
      efin <= launch.fin;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pt_valid <= 1'b0;
    end else if (adv) begin
      pt_valid <= 1'b1;
    end else if (pt_ready) begin
      pt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      point_x  <= $signed(sel_x[PW-1:0]);
      point_y  <= $signed(sel_y[PW-1:0]);
      last     <= (idx == IDX_LAST);
      done_res <= (idx == IDX_LAST) && efin;
    end
  end

  // Completion is only ever flagged on the closing point of a step.
  a_done_on_last: assert property (@(posedge clk) disable iff (rst)
    pt_valid |-> (!done_res || last))
    else $error("done_res without last");

  // A launch restarts the point walk at the first octant.
  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    launch.go |=> (busy && idx == '0))
    else $error("emitter did not start after launch");

  // The emitter goes idle only after handing over its closing point.
  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (pt_valid && last))
    else $error("emitter went idle before its closing point");

endmodule

@@ design/midpoint_circle_outline_unit.sv @@
`timescale 1ns / 1ps
// Midpoint circle outline unit. A start item (command 0) loads the centre and
// radius and yields no points. Each step item (command 1) of an active circle
// yields eight mirrored outline points, one per cycle on the point channel
// while pt_ready does not hold it back. The next item is taken in the cycle the
// eighth point of the current step enters the result register, so items follow
// each other without gaps. The last point of a step carries last, and done_res
// when the circle is complete.
// Depends on mco_pkg, mco_core and mco_emit.
module midpoint_circle_outline_unit #(
  parameter int COORD_BITS  = 12,
  parameter int RADIUS_BITS = 11
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  logic                          command,
  input  logic [COORD_BITS-1:0]         centre_x,
  input  logic [COORD_BITS-1:0]         centre_y,
  input  logic [RADIUS_BITS-1:0]        circle_radius,
  output logic                          pt_valid,
  input  logic                          pt_ready,
  output logic signed [COORD_BITS+1:0]  point_x,
  output logic signed [COORD_BITS+1:0]  point_y,
  output logic                          last,
  output logic                          done_res
);

  mco_pkg::launch_t              launch;
  logic                          emit_free;
  logic signed [RADIUS_BITS:0]   step_x;
  logic [RADIUS_BITS-1:0]        step_y;
  logic [COORD_BITS-1:0]         step_cx;
  logic [COORD_BITS-1:0]         step_cy;

  mco_core #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_core (
    .clk           (clk),
    .rst           (rst),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .command       (command),
    .centre_x      (centre_x),
    .centre_y      (centre_y),
    .circle_radius (circle_radius),
    .emit_free     (emit_free),
    .launch        (launch),
    .step_x        (step_x),
    .step_y        (step_y),
    .step_cx       (step_cx),
    .step_cy       (step_cy)
  );

  mco_emit #(
    .COORD_BITS  (COORD_BITS),
    .RADIUS_BITS (RADIUS_BITS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .launch    (launch),
    .step_x    (step_x),
    .step_y    (step_y),
    .step_cx   (step_cx),
    .step_cy   (step_cy),
    .emit_free (emit_free),
    .pt_valid  (pt_valid),
    .pt_ready  (pt_ready),
    .point_x   (point_x),
    .point_y   (point_y),
    .last      (last),
    .done_res  (done_res)
  );

endmodule

@@ bench/tb_midpoint_circle_outline_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for midpoint_circle_outline_unit: a directed table, then random
// start/step sequences, with every emitted outline point compared against a local midpoint
// circle predictor. Depends on mco_pkg and the unit under test.
module tb_midpoint_circle_outline_unit;

  localparam int CW = 12;
  localparam int RW = 11;
  localparam int PW = CW + 2;
  localparam int DIR_ROWS = 25;
  localparam int RANDOM_ITEMS = 360;

  typedef struct packed {
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic          last;
    logic          done;
  } outline_point_t;

  // One directed item. When typed is set, n_pts copies of (px, py) are expected, with last
  // and fin on the eighth; otherwise the predictor supplies the expectation.
  typedef struct packed {
    logic          cmd;
    logic [CW-1:0] cx;
    logic [CW-1:0] cy;
    logic [RW-1:0] r;
    logic          typed;
    logic [3:0]    n_pts;
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic          fin;
  } stim_row_t;

  stim_row_t dir_rows [DIR_ROWS] = '{
    // Step before any start does nothing.
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b1, 4'd0, 14'd0,    14'd0,    1'b0},
    // A zero radius leaves the unit inactive.
    '{mco_pkg::CMD_START, 12'd100,  12'd200,  11'd0,    1'b1, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b1, 4'd0, 14'd0,    14'd0,    1'b0},
    // Radius one: a single step of eight copies of the centre, then complete.
    '{mco_pkg::CMD_START, 12'd0,    12'd0,    11'd1,    1'b1, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd4095, 12'd4095, 11'd2047, 1'b1, 4'd8, 14'd0,    14'd0,    1'b1},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b1, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_START, 12'd4095, 12'd4095, 11'd1,    1'b1, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b1, 4'd8, 14'd4095, 14'd4095, 1'b1},
    // Largest radius at both corners of the coordinate range.
    '{mco_pkg::CMD_START, 12'd0,    12'd0,    11'd2047, 1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd4095, 12'd0,    11'd2047, 1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_START, 12'd4095, 12'd4095, 11'd2047, 1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd4095, 11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    // Radius two runs to completion, then one more step is ignored.
    '{mco_pkg::CMD_START, 12'd2048, 12'd2048, 11'd2,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    // A new start in the middle of a circle replaces it.
    '{mco_pkg::CMD_START, 12'd1000, 12'd3000, 11'd5,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_START, 12'd37,   12'd55,   11'd3,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0},
    '{mco_pkg::CMD_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'd0,    14'd0,    1'b0}
  };

  logic                  clk;
  logic                  rst;
  logic                  cmd_valid;
  logic                  cmd_ready;
  logic                  command;
  logic [CW-1:0]         centre_x;
  logic [CW-1:0]         centre_y;
  logic [RW-1:0]         circle_radius;
  logic                  pt_valid;
  logic                  pt_ready;
  logic signed [PW-1:0]  point_x;
  logic signed [PW-1:0]  point_y;
  logic                  last;
  logic                  done_res;

  midpoint_circle_outline_unit #(
    .COORD_BITS (CW),
    .RADIUS_BITS(RW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_ready    (cmd_ready),
    .command      (command),
    .centre_x     (centre_x),
    .centre_y     (centre_y),
    .circle_radius(circle_radius),
    .pt_valid     (pt_valid),
    .pt_ready     (pt_ready),
    .point_x      (point_x),
    .point_y      (point_y),
    .last         (last),
    .done_res     (done_res)
  );

  // Predictor state of the circle walk.
  int circ_x, circ_y, circ_tx, circ_ty, circ_err;
  int circ_cx, circ_cy, circ_r;
  bit circ_active;

  outline_point_t pending_points[$];
  outline_point_t head_pt;

  int  mismatches;
  int  points_checked;
  int  n_starts;
  int  n_steps;
  int  circles_done;
  int  stall_left;
  bit  calm;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Advances the predicted walk by one accepted item and, if asked, queues the points.
  task automatic walk_circle(input logic cmd, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                             input logic [RW-1:0] r, input bit queue_pts, output int n_pts);
    int ox[8];
    int oy[8];
    bit fin;
    outline_point_t pt;
    n_pts = 0;
    if (cmd == mco_pkg::CMD_START) begin
      circ_cx = int'(cx);
      circ_cy = int'(cy);
      circ_r = int'(r);
      circ_x = circ_r - 1;
      circ_y = 0;
      circ_tx = 1;
      circ_ty = 1;
      circ_err = 1 - 2 * circ_r;
      circ_active = (circ_x >= circ_y);
      return;
    end
    if (!circ_active || circ_x < circ_y) begin
      circ_active = 1'b0;
      return;
    end
    ox = '{circ_cx + circ_x, circ_cx + circ_x, circ_cx - circ_x, circ_cx - circ_x,
           circ_cx + circ_y, circ_cx + circ_y, circ_cx - circ_y, circ_cx - circ_y};
    oy = '{circ_cy - circ_y, circ_cy + circ_y, circ_cy - circ_y, circ_cy + circ_y,
           circ_cy - circ_x, circ_cy + circ_x, circ_cy - circ_x, circ_cy + circ_x};
    if (circ_err <= 0) begin
      circ_y += 1;
      circ_err += circ_ty;
      circ_ty += 2;
    end
    if (circ_err > 0) begin
      circ_x -= 1;
      circ_tx += 2;
      circ_err += circ_tx - 2 * circ_r;
    end
    fin = (circ_x < circ_y);
    if (fin) begin
      circ_active = 1'b0;
      circles_done++;
    end
    n_pts = 8;
    if (queue_pts) begin
      for (int k = 0; k < 8; k++) begin
        pt.px = PW'(ox[k]);
        pt.py = PW'(oy[k]);
        pt.last = (k == 7);
        pt.done = (k == 7) && fin;
        pending_points.push_back(pt);
      end
    end
  endtask

  // Presents one item after a random gap, waits for acceptance, then predicts it.
  // Returns at the accepting edge.
  task automatic send_item(input logic cmd, input logic [CW-1:0] cx, input logic [CW-1:0] cy,
                           input logic [RW-1:0] r, input bit typed_row, output int n_pts);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    @(negedge clk);
    if (gap > 0) begin
      cmd_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command <= cmd;
    centre_x <= cx;
    centre_y <= cy;
    circle_radius <= r;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (!cmd_ready);
    walk_circle(cmd, cx, cy, r, !typed_row, n_pts);
    if (cmd == mco_pkg::CMD_START) n_starts++;
    else if (n_pts > 0) n_steps++;
  endtask

  // Result side: stall a random number of cycles after each accepted point.
  always @(negedge clk) begin
    if (stall_left > 0) begin
      pt_ready <= 1'b0;
      stall_left = stall_left - 1;
    end else begin
      pt_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && pt_valid && pt_ready) begin
      points_checked++;
      if (pending_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected point (%0d,%0d) last=%b done=%b",
                   $realtime, point_x, point_y, last, done_res);
      end else begin
        head_pt = pending_points.pop_front();
        if (point_x !== head_pt.px || point_y !== head_pt.py || last !== head_pt.last ||
            done_res !== head_pt.done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected (%0d,%0d) last=%b done=%b, got (%0d,%0d) last=%b done=%b",
                     $realtime, $signed(head_pt.px), $signed(head_pt.py), head_pt.last,
                     head_pt.done, point_x, point_y, last, done_res);
        end
      end
      stall_left = calm ? 0 : $urandom_range(0, 7);
    end
  end

  initial begin
    #2_000_000;
    $display("midpoint_circle_outline_unit regression: fail");
    $finish;
  end

  initial begin
    int n_pts;
    int kind;
    int cap;
    int k;
    int productive;
    logic [RW-1:0] r;
    outline_point_t pt;

    rst = 1'b1;
    cmd_valid = 1'b0;
    command = mco_pkg::CMD_START;
    centre_x = '0;
    centre_y = '0;
    circle_radius = '0;
    pt_ready = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    mismatches = 0;
    points_checked = 0;
    n_starts = 0;
    n_steps = 0;
    circles_done = 0;
    circ_x = 0;
    circ_y = 0;
    circ_tx = 1;
    circ_ty = 1;
    circ_err = 0;
    circ_cx = 0;
    circ_cy = 0;
    circ_r = 0;
    circ_active = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIR_ROWS; i++) begin
      send_item(dir_rows[i].cmd, dir_rows[i].cx, dir_rows[i].cy, dir_rows[i].r,
                dir_rows[i].typed, n_pts);
      if (dir_rows[i].typed) begin
        for (int j = 0; j < int'(dir_rows[i].n_pts); j++) begin
          pt.px = dir_rows[i].px;
          pt.py = dir_rows[i].py;
          pt.last = (j == 7);
          pt.done = (j == 7) && dir_rows[i].fin;
          pending_points.push_back(pt);
        end
      end
    end

    // Mostly complete circles with random content; some are cut short by a new start,
    // and a few sequences are plain noise.
    productive = 0;
    while (productive < RANDOM_ITEMS) begin
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 9);
      if (kind <= 8) begin
        case ($urandom_range(0, 9))
          0: r = RW'($urandom_range(0, 2047));
          1: r = RW'($urandom_range(0, 3));
          default: r = RW'($urandom_range(4, 48));
        endcase
        send_item(mco_pkg::CMD_START, CW'($urandom_range(0, 4095)),
                  CW'($urandom_range(0, 4095)), r, 1'b0, n_pts);
        productive++;
        if (kind == 8) cap = $urandom_range(0, 3);
        else cap = (r > 64) ? $urandom_range(1, 24) : 1000;
        k = 0;
        while (circ_active && k < cap) begin
          send_item(mco_pkg::CMD_STEP, CW'($urandom), CW'($urandom), RW'($urandom), 1'b0,
                    n_pts);
          productive++;
          k++;
        end
        repeat ($urandom_range(0, 2)) begin
          send_item(mco_pkg::CMD_STEP, CW'($urandom), CW'($urandom), RW'($urandom), 1'b0,
                    n_pts);
          if (n_pts > 0) productive++;
        end
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_item(logic'($urandom_range(0, 1)), CW'($urandom), CW'($urandom),
                    RW'($urandom), 1'b0, n_pts);
          if (command == mco_pkg::CMD_START || n_pts > 0) productive++;
        end
      end
    end
    @(negedge clk);
    cmd_valid <= 1'b0;
    calm = 1'b0;

    while (pending_points.size() != 0) @(posedge clk);
    repeat (24) @(posedge clk);

    $display("Accepted %0d starts and %0d point-producing steps; %0d circles ran to completion.",
             n_starts, n_steps, circles_done);
    $display("Checked %0d outline points; %0d mismatches, %0d points still outstanding.",
             points_checked, mismatches, pending_points.size());
    if (mismatches == 0 && pending_points.size() == 0)
      $display("midpoint_circle_outline_unit regression: pass");
    else
      $display("midpoint_circle_outline_unit regression: fail");
    $finish;
  end

endmodule
